### rtl/core/isfp_pkg.sv
// Shared types, constants and band lookup for the synthesizer frequency programmer.
// No dependencies; used by every module in rtl/core.
package isfp_pkg;

   localparam int FREQ_W = 23;
   localparam int KHZ_W  = 20;
   localparam int WORD_W = 32;
   localparam int INT_W  = 8;
   localparam int CODE_W = 3;
   localparam int Y_W    = 23;
   localparam int PROD_W = 47;
   localparam int RECIP_SHIFT = 38;

   localparam logic [FREQ_W-1:0] FREQ_MIN  = 23'd35000;
   localparam logic [Y_W-1:0]    HALF_REF  = 23'd12500;
   localparam logic [Y_W-1:0]    REF_KHZ   = 23'd25000;
   // ceil(2^38 / 25000), exact floor for every dividend below 2^23
   localparam logic [PROD_W-1:0] RECIP_MULT = 47'd10995117;

   localparam logic [WORD_W-1:0] DIV_IMAGE_RST = 32'h00E1403C;
   localparam logic [WORD_W-1:0] PS_IMAGE_RST  = 32'h000083E9;
   localparam logic [WORD_W-1:0] INT_IMAGE_RST = 32'h00400000;
   // divider code equals log2 of the output divider
   localparam logic [CODE_W-1:0] DIV_CODE_RST  = 3'd6;
   localparam logic              PS8_RST       = 1'b0;
   localparam logic [CODE_W-1:0] DIV_CODE_TOP  = 3'd6;

   localparam logic [FREQ_W-1:0] BAND_UPPER [8] = '{
      23'd56250, 23'd68750, 23'd112500, 23'd137500,
      23'd225000, 23'd275000, 23'd450000, 23'd550000
   };

   typedef struct packed {
      logic              err;
      logic [CODE_W-1:0] div_code;
      logic              ps8;
      logic [INT_W-1:0]  intv;
      logic [KHZ_W-1:0]  khz;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_ch_type;

   function automatic logic [3:0] classify_band(input logic [FREQ_W-1:0] f);
      logic [3:0] idx;
      idx = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (f < BAND_UPPER[i]) begin
            idx = 4'(i);
         end
      end
      if (f < FREQ_MIN) begin
         idx = 4'd8;
      end
      return idx;
   endfunction

endpackage

### rtl/core/isfp_front.sv
// Front end: accepts requests, sorts them into bands and computes INT and kHz.
// Depends on isfp_pkg.
module isfp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [isfp_pkg::FREQ_W-1:0] req_frequency_khz,
   output isfp_pkg::job_ch_type       job_out,
   input  logic                       job_ready
);

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_err_ff;
   logic [isfp_pkg::CODE_W-1:0]   s1_code_ff;
   logic                          s1_ps8_ff;
   logic [isfp_pkg::Y_W-1:0]      s1_y_ff;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_err_ff;
   logic [isfp_pkg::CODE_W-1:0]   s2_code_ff;
   logic                          s2_ps8_ff;
   logic [isfp_pkg::INT_W-1:0]    s2_intv_ff;
   logic                          s1_en, s2_en;
   logic [3:0]                    band;
   logic [isfp_pkg::CODE_W-1:0]   code_in;
   logic [isfp_pkg::Y_W-1:0]      y_in;
   logic [isfp_pkg::PROD_W-1:0]   prod;
   logic [isfp_pkg::Y_W-1:0]      khz_prod;

   assign s2_en = !s2_valid_ff || job_ready;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign s1_valid_in = req_valid;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      band    = isfp_pkg::classify_band(req_frequency_khz);
      code_in = isfp_pkg::DIV_CODE_TOP - isfp_pkg::CODE_W'(band[2:1]);
      y_in    = (isfp_pkg::Y_W'(req_frequency_khz[19:0]) << code_in) + isfp_pkg::HALF_REF;
      prod    = isfp_pkg::PROD_W'(s1_y_ff) * isfp_pkg::RECIP_MULT;
      khz_prod = isfp_pkg::Y_W'(s2_intv_ff) * isfp_pkg::REF_KHZ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_en) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_err_ff  <= band[3];
         s1_code_ff <= code_in;
         s1_ps8_ff  <= band[0];
         s1_y_ff    <= y_in;
      end
      if (s2_en) begin
         s2_err_ff  <= s1_err_ff;
         s2_code_ff <= s1_code_ff;
         s2_ps8_ff  <= s1_ps8_ff;
         s2_intv_ff <= prod[isfp_pkg::RECIP_SHIFT+isfp_pkg::INT_W-1:isfp_pkg::RECIP_SHIFT];
      end
   end

   always_comb begin
      job_out.valid        = s2_valid_ff;
      job_out.job.err      = s2_err_ff;
      job_out.job.div_code = s2_code_ff;
      job_out.job.ps8      = s2_ps8_ff;
      job_out.job.intv     = s2_intv_ff;
      job_out.job.khz      = isfp_pkg::KHZ_W'(khz_prod >> s2_code_ff);
   end

endmodule

### rtl/core/isfp_queue.sv
// Two-entry queue of classified jobs between front end and back end.
// Depends on isfp_pkg.
module isfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  isfp_pkg::job_ch_type  wr_in,
   output logic                  wr_ready,
   output isfp_pkg::job_ch_type  rd_out,
   input  logic                  rd_pop
);

   isfp_pkg::job_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign push = wr_in.valid && wr_ready;
   assign pop  = rd_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
      rd_out.valid = (count_ff != 2'd0);
      rd_out.job   = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_in.job;
      end
   end

endmodule

### rtl/core/isfp_back.sv
// Back end: holds register images, patches and emits words through an output register.
// Depends on isfp_pkg.
module isfp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  isfp_pkg::job_ch_type        job_in,
   output logic                        job_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [isfp_pkg::WORD_W-1:0] rsp_register_word,
   output logic                        rsp_last_word,
   output logic                        rsp_status,
   output logic [isfp_pkg::KHZ_W-1:0]  rsp_programmed_khz
);

   logic [isfp_pkg::WORD_W-1:0] div_img_ff, div_img_in;
   logic [isfp_pkg::WORD_W-1:0] ps_img_ff, ps_img_in;
   logic [isfp_pkg::WORD_W-1:0] int_img_ff, int_img_in;
   logic [isfp_pkg::CODE_W-1:0] div_code_ff, div_code_in;
   logic                        ps8_ff, ps8_in;
   logic                        valid_ff, valid_in;
   logic [isfp_pkg::WORD_W-1:0] word_ff, word_in;
   logic                        last_ff, last_in;
   logic                        status_ff, status_in;
   logic [isfp_pkg::KHZ_W-1:0]  khz_ff, khz_in;
   logic                        fire, need_div, need_ps;
   isfp_pkg::job_type           job;

   assign job  = job_in.job;
   assign fire = job_in.valid && (!valid_ff || rsp_ready);
   assign need_div = !job.err && (job.div_code != div_code_ff);
   assign need_ps  = !job.err && (job.ps8 != ps8_ff);
   assign job_pop  = fire && !need_div && !need_ps;

   always_comb begin
      div_img_in  = div_img_ff;
      ps_img_in   = ps_img_ff;
      int_img_in  = int_img_ff;
      div_code_in = div_code_ff;
      ps8_in      = ps8_ff;
      valid_in    = valid_ff && !rsp_ready;
      word_in     = word_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      khz_in      = khz_ff;
      if (fire) begin
         valid_in  = 1'b1;
         status_in = job.err;
         khz_in    = job.err ? '0 : job.khz;
         if (job.err) begin
            word_in = '0;
            last_in = 1'b1;
         end else if (need_div) begin
            div_img_in  = {div_img_ff[31:23], job.div_code, div_img_ff[19:0]};
            div_code_in = job.div_code;
            word_in     = div_img_in;
            last_in     = 1'b0;
         end else if (need_ps) begin
            ps_img_in = {ps_img_ff[31:28], job.ps8, ps_img_ff[26:0]};
            ps8_in    = job.ps8;
            word_in   = ps_img_in;
            last_in   = 1'b0;
         end else begin
            int_img_in = {int_img_ff[31], 8'd0, job.intv, int_img_ff[14:0]};
            word_in    = int_img_in;
            last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_img_ff  <= isfp_pkg::DIV_IMAGE_RST;
         ps_img_ff   <= isfp_pkg::PS_IMAGE_RST;
         int_img_ff  <= isfp_pkg::INT_IMAGE_RST;
         div_code_ff <= isfp_pkg::DIV_CODE_RST;
         ps8_ff      <= isfp_pkg::PS8_RST;
         valid_ff    <= 1'b0;
      end else begin
         div_img_ff  <= div_img_in;
         ps_img_ff   <= ps_img_in;
         int_img_ff  <= int_img_in;
         div_code_ff <= div_code_in;
         ps8_ff      <= ps8_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      khz_ff    <= khz_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_register_word  = word_ff;
   assign rsp_last_word      = last_ff;
   assign rsp_status         = status_ff;
   assign rsp_programmed_khz = khz_ff;

endmodule

### rtl/core/integer_n_synth_freq_programmer.sv
// Top level of the integer-N synthesizer frequency programmer.
// Depends on isfp_pkg, isfp_front, isfp_queue and isfp_back.
//
// Each request word (frequency in kHz) produces one to three response words: the
// patched divider word if the output divider changes, the patched prescaler word if
// the prescaler changes, then the integer word, flagged last. A request outside
// 35000..549999 kHz gives one error word and leaves all images untouched. The front
// end takes a request every cycle unless a full queue stalls it, into a two-stage
// pipeline (band compare, then the reciprocal multiply, with the kHz multiply after
// it) feeding a two-entry queue; the back end emits one word per cycle unless
// rsp_ready is low, and holds a request until its last word is emitted. The first
// response word passes both front-end stages, the queue and the output register.
module integer_n_synth_freq_programmer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [isfp_pkg::FREQ_W-1:0] req_frequency_khz,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [isfp_pkg::WORD_W-1:0] rsp_register_word,
   output logic                        rsp_last_word,
   output logic                        rsp_status,
   output logic [isfp_pkg::KHZ_W-1:0]  rsp_programmed_khz
);

   isfp_pkg::job_ch_type front_job;
   isfp_pkg::job_ch_type head_job;
   logic                 queue_ready;
   logic                 head_pop;

   isfp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frequency_khz (req_frequency_khz),
      .job_out           (front_job),
      .job_ready         (queue_ready)
   );

   isfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_in    (front_job),
      .wr_ready (queue_ready),
      .rd_out   (head_job),
      .rd_pop   (head_pop)
   );

   isfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_in             (head_job),
      .job_pop            (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_register_word  (rsp_register_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_status         (rsp_status),
      .rsp_programmed_khz (rsp_programmed_khz)
   );

endmodule

### tb/isfp_checker.sv
// Watches both channels of the frequency programmer, predicts the register words for
// every accepted request and compares each returned word field by field in order.
// Depends on isfp_pkg for widths and the reset images of the three register words.
module isfp_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [isfp_pkg::FREQ_W-1:0] req_frequency_khz,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [isfp_pkg::WORD_W-1:0] rsp_register_word,
   input  logic                        rsp_last_word,
   input  logic                        rsp_status,
   input  logic [isfp_pkg::KHZ_W-1:0]  rsp_programmed_khz,
   output int                          error_count,
   output int                          pending_words,
   output int                          words_checked,
   output int                          rejected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REF_STEP   = 25000;
   localparam int unsigned HALF_STEP  = 12500;
   localparam int unsigned FREQ_LOW   = 35000;
   localparam logic        STATUS_OK    = 1'b0;
   localparam logic        STATUS_RANGE = 1'b1;
   localparam logic [isfp_pkg::WORD_W-1:0] DIV_FIELD = 32'h0070_0000;
   localparam logic [isfp_pkg::WORD_W-1:0] PS_FIELD  = 32'h0800_0000;
   localparam logic [isfp_pkg::WORD_W-1:0] INT_FIELD = 32'h7FFF_8000;
   localparam int DIV_POS = 20;
   localparam int PS_POS  = 27;
   localparam int INT_POS = 15;
   localparam logic [isfp_pkg::CODE_W-1:0] DIV8_CODE  = 3'd3;
   localparam logic [isfp_pkg::CODE_W-1:0] DIV16_CODE = 3'd4;
   localparam logic [isfp_pkg::CODE_W-1:0] DIV32_CODE = 3'd5;
   localparam logic [isfp_pkg::CODE_W-1:0] DIV64_CODE = 3'd6;

   localparam int unsigned BAND_TOP [8] = '{56250, 68750, 112500, 137500,
                                            225000, 275000, 450000, 550000};
   localparam logic [7:0] BAND_DIV [8] = '{8'd64, 8'd64, 8'd32, 8'd32,
                                           8'd16, 8'd16, 8'd8, 8'd8};
   localparam logic [3:0] BAND_PS [8] = '{4'd4, 4'd8, 4'd4, 4'd8,
                                          4'd4, 4'd8, 4'd4, 4'd8};

   typedef struct packed {
      logic [isfp_pkg::WORD_W-1:0] word;
      logic                        last;
      logic                        status;
      logic [isfp_pkg::KHZ_W-1:0]  khz;
   } synth_word_type;

   synth_word_type              expected_words [$];
   synth_word_type              want;
   logic [isfp_pkg::WORD_W-1:0] divider_word;
   logic [isfp_pkg::WORD_W-1:0] prescaler_word;
   logic [isfp_pkg::WORD_W-1:0] integer_word;
   logic [7:0]                  active_divider;
   logic [3:0]                  active_prescaler;
   int                          mismatches;
   int                          checked;
   int                          rejected;

   function automatic void predict_words(input logic [isfp_pkg::FREQ_W-1:0] f);
      int                          band;
      logic [7:0]                  divider;
      logic [3:0]                  prescaler;
      logic [31:0]                 scaled;
      logic [31:0]                 count;
      logic [31:0]                 khz;
      logic [isfp_pkg::CODE_W-1:0] code;
      logic [isfp_pkg::WORD_W-1:0] words [$];
      synth_word_type              item;
      band = -1;
      if (f >= FREQ_LOW) begin
         for (int i = 7; i >= 0; i--) begin
            if (f < BAND_TOP[i]) begin
               band = i;
            end
         end
      end
      if (band < 0) begin
         rejected++;
         item = '{word: '0, last: 1'b1, status: STATUS_RANGE, khz: '0};
         expected_words.push_back(item);
         return;
      end
      divider   = BAND_DIV[band];
      prescaler = BAND_PS[band];
      scaled    = f * divider;
      count     = ((scaled + HALF_STEP) / REF_STEP) & 32'h0000_FFFF;
      khz       = (REF_STEP * count) / divider;
      case (divider)
         8'd8:    code = DIV8_CODE;
         8'd16:   code = DIV16_CODE;
         8'd32:   code = DIV32_CODE;
         default: code = DIV64_CODE;
      endcase
      if (divider != active_divider) begin
         divider_word = (divider_word & ~DIV_FIELD) |
                        (isfp_pkg::WORD_W'(code) << DIV_POS);
         words.push_back(divider_word);
      end
      if (prescaler != active_prescaler) begin
         prescaler_word = (prescaler_word & ~PS_FIELD) |
                          (isfp_pkg::WORD_W'(prescaler == 4'd8) << PS_POS);
         words.push_back(prescaler_word);
      end
      integer_word = (integer_word & ~INT_FIELD) | (count << INT_POS);
      words.push_back(integer_word);
      active_divider   = divider;
      active_prescaler = prescaler;
      foreach (words[k]) begin
         item = '{word: words[k], last: (k == words.size() - 1), status: STATUS_OK,
                  khz: khz[isfp_pkg::KHZ_W-1:0]};
         expected_words.push_back(item);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         divider_word     = isfp_pkg::DIV_IMAGE_RST;
         prescaler_word   = isfp_pkg::PS_IMAGE_RST;
         integer_word     = isfp_pkg::INT_IMAGE_RST;
         active_divider   = 8'd64;
         active_prescaler = 4'd4;
         mismatches       = 0;
         checked          = 0;
         rejected         = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_words(req_frequency_khz);
         end
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, got 0x%0h", $time,
                        rsp_register_word);
            end else begin
               want = expected_words.pop_front();
               compare_field("register_word", want.word, rsp_register_word);
               compare_field("last_word", want.last, rsp_last_word);
               compare_field("status", want.status, rsp_status);
               compare_field("programmed_khz", want.khz, rsp_programmed_khz);
            end
         end
      end
      error_count    <= mismatches;
      pending_words  <= expected_words.size();
      words_checked  <= checked;
      rejected_count <= rejected;
   end

endmodule

### tb/testbench.sv
// Top of the frequency programmer testbench: clock, reset, request and response
// stimulus with random pauses, a stall watchdog and the final verdict.
// Depends on isfp_pkg, the programmer RTL and isfp_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 3000;
   localparam int RANDOM_ITEMS = 146;
   localparam int unsigned FREQ_LOW  = 35000;
   localparam int unsigned FREQ_HIGH = 550000;
   localparam int unsigned BAND_TOP [8] = '{56250, 68750, 112500, 137500,
                                            225000, 275000, 450000, 550000};
   localparam logic [isfp_pkg::FREQ_W-1:0] DIRECTED [24] = '{
      23'd0, 23'd34999, 23'd35000, 23'd35000, 23'd56249, 23'd56250, 23'd68749,
      23'd68750, 23'd112499, 23'd112500, 23'd137499, 23'd137500, 23'd224999,
      23'd225000, 23'd274999, 23'd275000, 23'd449999, 23'd450000, 23'd549999,
      23'd550000, 23'd8388607, 23'd35000, 23'd4194304, 23'd549999
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [isfp_pkg::FREQ_W-1:0] req_frequency_khz = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [isfp_pkg::WORD_W-1:0] rsp_register_word;
   logic                        rsp_last_word;
   logic                        rsp_status;
   logic [isfp_pkg::KHZ_W-1:0]  rsp_programmed_khz;

   int error_count;
   int pending_words;
   int words_checked;
   int rejected_count;
   int sent_count = 0;
   int idle_cycles = 0;
   int rsp_pause = 0;
   int rsp_draw;
   bit send_quiet = 1'b1;
   bit recv_quiet = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   integer_n_synth_freq_programmer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frequency_khz  (req_frequency_khz),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_register_word  (rsp_register_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_status         (rsp_status),
      .rsp_programmed_khz (rsp_programmed_khz)
   );

   isfp_checker freq_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frequency_khz  (req_frequency_khz),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_register_word  (rsp_register_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_status         (rsp_status),
      .rsp_programmed_khz (rsp_programmed_khz),
      .error_count        (error_count),
      .pending_words      (pending_words),
      .words_checked      (words_checked),
      .rejected_count     (rejected_count)
   );

   function automatic int draw_pause(input bit quiet);
      if (quiet) begin
         return 0;
      end
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return $urandom_range(1, 3);
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   task automatic send_frequency(input logic [isfp_pkg::FREQ_W-1:0] f);
      int pause;
      pause = draw_pause(send_quiet);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_frequency_khz <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // stall the response side for a drawn number of cycles after each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_pause <= 0;
      end else if (rsp_pause > 0) begin
         rsp_pause <= rsp_pause - 1;
         if (rsp_pause == 1) begin
            rsp_ready <= 1'b1;
         end
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
      end else if (rsp_valid) begin
         rsp_draw = draw_pause(recv_quiet);
         if (rsp_draw > 0) begin
            rsp_ready <= 1'b0;
            rsp_pause <= rsp_draw;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a handshake", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                          band;
      int unsigned                 lo;
      int unsigned                 hi;
      logic [isfp_pkg::FREQ_W-1:0] f;
      band = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         send_frequency(DIRECTED[i]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_quiet = (n >= 60 && n < 100) || (n >= 140 && n < 155);
         recv_quiet = (n >= 100 && n < 130) || (n >= 140 && n < 155);
         if ($urandom_range(0, 9) < 2) begin
            if ($urandom_range(0, 1) == 0) begin
               f = isfp_pkg::FREQ_W'($urandom_range(0, FREQ_LOW - 1));
            end else begin
               f = isfp_pkg::FREQ_W'($urandom_range(FREQ_HIGH,
                                                    (1 << isfp_pkg::FREQ_W) - 1));
            end
         end else begin
            // keep the band often so that single-word requests show up
            if ($urandom_range(0, 9) >= 4) begin
               band = $urandom_range(0, 7);
            end
            lo = (band == 0) ? FREQ_LOW : BAND_TOP[band - 1];
            hi = BAND_TOP[band] - 1;
            case ($urandom_range(0, 5))
               0:       f = isfp_pkg::FREQ_W'(lo + $urandom_range(0, 3));
               1:       f = isfp_pkg::FREQ_W'(hi - $urandom_range(0, 3));
               default: f = isfp_pkg::FREQ_W'($urandom_range(lo, hi));
            endcase
         end
         send_frequency(f);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d frequency requests, %0d of them out of range;", sent_count,
               rejected_count);
      $display("checked %0d register words across all eight bands.", words_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
